### sv/png_scanline_unfilter_macros.svh
// assertion macros used by the top-level file
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// property must hold at every edge outside reset
`define PSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define PSU_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### sv/psu_pkg.sv
package psu_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_BPP = 4;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int LANE_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	localparam int ROWLEN_W = ADDR_W + 1;
	localparam int DIGITS = (ADDR_W + 1) / 2;

	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 16;
	localparam int BPP_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

	localparam logic [2:0] FILT_NONE = 3'd0;
	localparam logic [2:0] FILT_SUB = 3'd1;
	localparam logic [2:0] FILT_UP = 3'd2;
	localparam logic [2:0] FILT_AVG = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_row;
		logic       end_of_image;
		logic       bad_filter;
	} out_item_t;

	typedef struct packed {
		logic              bad;
		logic [7:0]        in_byte;
		logic [ADDR_W-1:0] pos;
		logic [LANE_W-1:0] lane;
		logic              left_ok;
		logic              first_row;
		logic [2:0]        filt;
		logic              eor;
		logic              eoi;
	} stage_t;

	function automatic logic [1:0] mod3(input logic [ADDR_W-1:0] x);
		logic [2*DIGITS-1:0] xp;
		logic [4:0] s;
		logic [2:0] t;
		xp = (2*DIGITS)'(x);
		s = '0;
		for (int i = 0; i < DIGITS; i++) begin
			s = s + 5'(xp[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] p;
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [7:0] r;
		p = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
		da = p - $signed({3'b0, a});
		db = p - $signed({3'b0, b});
		dc = p - $signed({3'b0, c});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			r = a;
		end else if (db <= dc) begin
			r = b;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

### sv/psu_line_ram.sv
module psu_line_ram #(
	parameter int DEPTH = 4096,
	parameter int DATA_W = 8,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/psu_ctrl.sv
module psu_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  psu_pkg::in_item_t                   in_item,
	input  logic                                s1_free,
	input  logic                                cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                stage_valid,
	output psu_pkg::stage_t                     stage,
	output logic                                rd_en,
	output logic [psu_pkg::ADDR_W-1:0]          rd_addr
);

	logic [psu_pkg::WIDTH_W-1:0]  width_q;
	logic [psu_pkg::HEIGHT_W-1:0] height_q;
	logic [psu_pkg::BPP_W-1:0]    bpp_q;

	logic [psu_pkg::ADDR_W-1:0]   pos_q;
	logic [psu_pkg::HEIGHT_W-1:0] row_q;
	logic [2:0]                   filt_q;
	logic                         await_q;
	logic                         first_q;
	logic                         halt_q;

	logic                         stage_valid_s1;
	psu_pkg::stage_t              stage_s1;

	logic [psu_pkg::WIDTH_W-1:0]  w_eff;
	logic [psu_pkg::HEIGHT_W-1:0] h_eff;
	logic [psu_pkg::BPP_W-1:0]    bpp_eff;
	logic [psu_pkg::ROWLEN_W-1:0] row_len;

	logic                         halt_c;
	logic                         await_c;
	logic                         first_c;
	logic [psu_pkg::HEIGHT_W-1:0] row_c;
	logic [psu_pkg::ADDR_W-1:0]   pos_c;
	logic                         eor;
	logic                         eoi;
	logic [psu_pkg::LANE_W-1:0]   lane;

	logic                         halt_d;
	logic                         await_d;
	logic                         first_d;
	logic [psu_pkg::HEIGHT_W-1:0] row_d;
	logic [psu_pkg::ADDR_W-1:0]   pos_d;
	logic [2:0]                   filt_d;
	logic                         has_res;
	logic                         is_bad;
	logic                         is_data;

	// clamped register values
	always_comb begin
		if (width_q == '0) begin
			w_eff = psu_pkg::WIDTH_W'(1);
		end else if (width_q > psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH)) begin
			w_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (bpp_q == '0) begin
			bpp_eff = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_BPP)) begin
			bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_BPP);
		end else begin
			bpp_eff = bpp_q;
		end
		h_eff = (height_q == '0) ? psu_pkg::HEIGHT_W'(1) : height_q;
		row_len = psu_pkg::ROWLEN_W'(w_eff) * psu_pkg::ROWLEN_W'(bpp_eff);
	end

	always_comb begin
		halt_c = halt_q & ~in_item.image_start;
		await_c = await_q | in_item.image_start;
		first_c = first_q | in_item.image_start;
		row_c = in_item.image_start ? '0 : row_q;
		pos_c = in_item.image_start ? '0 : pos_q;

		eor = (psu_pkg::ROWLEN_W'(pos_c) + psu_pkg::ROWLEN_W'(1)) >= row_len;
		eoi = eor && ((17'(row_c) + 17'd1) >= 17'(h_eff));

		case (bpp_eff)
			3'd2: lane = psu_pkg::LANE_W'(pos_c[0]);
			3'd3: lane = psu_pkg::LANE_W'(psu_pkg::mod3(pos_c));
			3'd4: lane = psu_pkg::LANE_W'(pos_c[1:0]);
			default: lane = '0;
		endcase

		halt_d = halt_c;
		await_d = await_c;
		first_d = first_c;
		row_d = row_c;
		pos_d = pos_c;
		filt_d = filt_q;
		has_res = 1'b0;
		is_bad = 1'b0;
		is_data = 1'b0;

		if (!halt_c) begin
			if (await_c) begin
				if (in_item.in_byte > 8'(psu_pkg::FILT_PAETH)) begin
					halt_d = 1'b1;
					has_res = 1'b1;
					is_bad = 1'b1;
				end else begin
					filt_d = in_item.in_byte[2:0];
					await_d = 1'b0;
					pos_d = '0;
				end
			end else begin
				has_res = 1'b1;
				is_data = 1'b1;
				if (eor) begin
					await_d = 1'b1;
					pos_d = '0;
					if (eoi) begin
						row_d = '0;
						first_d = 1'b1;
					end else begin
						row_d = row_c + psu_pkg::HEIGHT_W'(1);
						first_d = 1'b0;
					end
				end else begin
					pos_d = pos_c + psu_pkg::ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= psu_pkg::WIDTH_W'(1);
			height_q <= psu_pkg::HEIGHT_W'(1);
			bpp_q <= psu_pkg::BPP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				psu_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data[psu_pkg::WIDTH_W-1:0];
				psu_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[psu_pkg::HEIGHT_W-1:0];
				psu_pkg::CFG_BYTES_PER_PIXEL: bpp_q <= cfg_data[psu_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
			filt_q <= psu_pkg::FILT_NONE;
			await_q <= 1'b1;
			first_q <= 1'b1;
			halt_q <= 1'b0;
			stage_valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= pos_d;
				row_q <= row_d;
				filt_q <= filt_d;
				await_q <= await_d;
				first_q <= first_d;
				halt_q <= halt_d;
			end
			if (s1_free) begin
				stage_valid_s1 <= take & has_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stage_s1.bad <= is_bad;
			stage_s1.in_byte <= in_item.in_byte;
			stage_s1.pos <= pos_c;
			stage_s1.lane <= lane;
			stage_s1.left_ok <= pos_c >= psu_pkg::ADDR_W'(bpp_eff);
			stage_s1.first_row <= first_c;
			stage_s1.filt <= filt_q;
			stage_s1.eor <= eor;
			stage_s1.eoi <= eoi;
		end
	end

	assign stage_valid = stage_valid_s1;
	assign stage = stage_s1;
	assign rd_en = take & is_data;
	assign rd_addr = pos_c;

endmodule

### sv/psu_recon.sv
module psu_recon (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       stage_valid,
	input  psu_pkg::stage_t            stage,
	input  logic [7:0]                 rd_data,
	input  logic                       out_stall,
	output logic                       s1_free,
	output logic                       out_valid,
	output psu_pkg::out_item_t         out_item,
	output logic                       ram_we,
	output logic [psu_pkg::ADDR_W-1:0] ram_addr,
	output logic [7:0]                 ram_data
);

	logic [7:0] left_q [psu_pkg::MAX_BPP];
	logic [7:0] ul_q [psu_pkg::MAX_BPP];
	logic       out_valid_q;
	psu_pkg::out_item_t out_q;

	logic       adv;
	logic [7:0] above;
	logic [7:0] left;
	logic [7:0] ul;
	logic [8:0] sum9;
	logic [7:0] pred;
	logic [7:0] val;

	assign s1_free = !stage_valid || !out_valid_q || !out_stall;
	assign adv = stage_valid && (!out_valid_q || !out_stall);

	always_comb begin
		above = stage.first_row ? 8'd0 : rd_data;
		left = stage.left_ok ? left_q[stage.lane] : 8'd0;
		ul = (stage.left_ok && !stage.first_row) ? ul_q[stage.lane] : 8'd0;
		sum9 = 9'(left) + 9'(above);
		case (stage.filt)
			psu_pkg::FILT_SUB: pred = left;
			psu_pkg::FILT_UP: pred = above;
			psu_pkg::FILT_AVG: pred = sum9[8:1];
			psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(left, above, ul);
			default: pred = 8'd0;
		endcase
		val = stage.in_byte + pred;
	end

	// neighbour history per lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psu_pkg::MAX_BPP; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i] <= 8'd0;
			end
		end else if (adv && !stage.bad) begin
			left_q[stage.lane] <= val;
			ul_q[stage.lane] <= above;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (stage.bad) begin
				out_q.out_byte <= 8'd0;
				out_q.end_of_row <= 1'b0;
				out_q.end_of_image <= 1'b0;
				out_q.bad_filter <= 1'b1;
			end else begin
				out_q.out_byte <= val;
				out_q.end_of_row <= stage.eor;
				out_q.end_of_image <= stage.eoi;
				out_q.bad_filter <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign ram_we = adv && !stage.bad;
	assign ram_addr = stage.pos;
	assign ram_data = val;

endmodule

### sv/png_scanline_unfilter.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_item (in_byte, image_start)
// out      output     out_valid / out_stall  out_item (out_byte, flags)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// one item a cycle while in_stall is low; a data byte is registered in the first stage, then in the output register
// the first stage reads the line store, the second rebuilds the byte into the output register
// a valid filter byte gives no result; a bad one gives a bad_filter item and halts until image_start
// reset clears control and history; the line store is not cleared
// in_stall rises only while the second stage holds an item behind a stalled output
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  psu_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output psu_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                       take;
	logic                       s1_free;
	logic                       stage_valid;
	psu_pkg::stage_t            stage;
	logic                       rd_en;
	logic [psu_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                 rd_data;
	logic                       ram_we;
	logic [psu_pkg::ADDR_W-1:0] ram_addr;
	logic [7:0]                 ram_data;

	assign in_stall = !s1_free;
	assign take = in_valid && s1_free;

	psu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_item     (in_item),
		.s1_free     (s1_free),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stage_valid (stage_valid),
		.stage       (stage),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	psu_line_ram #(
		.DEPTH  (psu_pkg::STORE_DEPTH),
		.DATA_W (8)
	) u_line_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_addr),
		.wr_data (ram_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psu_recon u_recon (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_valid (stage_valid),
		.stage       (stage),
		.rd_data     (rd_data),
		.out_stall   (out_stall),
		.s1_free     (s1_free),
		.out_valid   (out_valid),
		.out_item    (out_item),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_data    (ram_data)
	);

	`PSU_NEVER(a_ram_same_addr, ram_we && rd_en && (ram_addr == rd_addr), "line store read and write collide")
	`PSU_ASSERT(a_stall_needs_item, in_stall |-> stage_valid, "input stalled with empty stage")
	`PSU_ASSERT(a_eoi_on_eor, out_valid && out_item.end_of_image |-> out_item.end_of_row, "image end off row end")

endmodule
